// File: sv/modbus_rtu_register_slave_core_assert.svh
// Assertion macros for the Modbus RTU register slave.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef MODBUS_RTU_REGISTER_SLAVE_CORE_ASSERT_SVH
`define MODBUS_RTU_REGISTER_SLAVE_CORE_ASSERT_SVH

`define MRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define MRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/mrs_pkg.sv
// Package of the Modbus RTU register slave: sizes, codes, frame descriptor, CRC step.
// No dependencies.
package mrs_pkg;

    localparam int NUM_REGS  = 16;
    localparam int MAX_FRAME = 64;
    localparam int REG_AW    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int FR_AW     = $clog2(MAX_FRAME);
    localparam int RAM_DEPTH = 2 * MAX_FRAME;
    localparam int HDR_LEN   = 7;

    localparam logic [7:0] FN_READ       = 8'h03;
    localparam logic [7:0] FN_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FN_WRITE_MANY = 8'h10;

    localparam logic [2:0] ST_REPLIED   = 3'd0;
    localparam logic [2:0] ST_CRC_BAD   = 3'd1;
    localparam logic [2:0] ST_OTHER     = 3'd2;
    localparam logic [2:0] ST_BROADCAST = 3'd3;
    localparam logic [2:0] ST_BAD_FN    = 3'd4;
    localparam logic [2:0] ST_LENGTH    = 3'd5;
    localparam logic [2:0] ST_RANGE     = 3'd6;

    localparam logic [7:0] DEV_ADDR_RST = 8'h02;

    typedef struct packed {
        logic [6:0]              n;
        logic                    ovf;
        logic                    crc_ok;
        logic                    bank;
        logic [HDR_LEN-1:0][7:0] hdr;
    } t_desc;

    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int j = 0; j < 8; j++) begin
            if (c[0]) begin
                c = (c >> 1) ^ 16'hA001;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/mrs_in_if.sv
// Receive byte channel of the Modbus RTU register slave.
// No dependencies.
interface mrs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;
    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

// File: sv/mrs_out_if.sv
// Reply and status channel of the Modbus RTU register slave.
// No dependencies.
interface mrs_out_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_last;
    logic [2:0] status;
    modport source (output valid, output tx_valid, output tx_byte, output tx_last,
                    output status, input ready);
    modport sink (input valid, input tx_valid, input tx_byte, input tx_last,
                  input status, output ready);
endinterface

// File: sv/mrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/mrs_front.sv
// Receive side: stores frame bytes, runs the CRC, captures the header, emits a descriptor.
// Depends on mrs_pkg and mrs_in_if.
module mrs_front (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    mrs_in_if.sink                  i_rx,
    input  logic                    i_q_full,
    output logic                    o_push,
    output mrs_pkg::t_desc          o_desc,
    output logic                    o_ram_we,
    output logic [mrs_pkg::FR_AW:0] o_ram_waddr,
    output logic [7:0]              o_ram_wdata
);

    logic [6:0]                          r_cnt, n_cnt;
    logic                                r_ovf, n_ovf;
    logic [15:0]                         r_crc, n_crc;
    logic                                r_bank;
    logic [mrs_pkg::HDR_LEN-1:0][7:0]    r_hdr, n_hdr;
    logic                                acc;
    logic                                room;

    assign i_rx.ready = !i_q_full;
    assign acc  = i_rx.valid && i_rx.ready;
    assign room = (r_cnt < 7'(mrs_pkg::MAX_FRAME));

    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_crc = r_crc;
        n_hdr = r_hdr;
        if (room) begin
            n_cnt = r_cnt + 7'd1;
            n_crc = mrs_pkg::crc_byte(r_crc, i_rx.rx_byte);
            if (r_cnt < 7'(mrs_pkg::HDR_LEN)) begin
                n_hdr[r_cnt[2:0]] = i_rx.rx_byte;
            end
        end else begin
            n_ovf = 1'b1;
        end
    end

    assign o_ram_we    = acc && room;
    assign o_ram_waddr = {r_bank, r_cnt[mrs_pkg::FR_AW-1:0]};
    assign o_ram_wdata = i_rx.rx_byte;

    assign o_push        = acc && i_rx.end_of_frame;
    assign o_desc.n      = n_cnt;
    assign o_desc.ovf    = n_ovf;
    assign o_desc.crc_ok = (n_crc == 16'h0000);
    assign o_desc.bank   = r_bank;
    assign o_desc.hdr    = n_hdr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_crc  <= 16'hFFFF;
            r_bank <= 1'b0;
        end else if (acc) begin
            if (i_rx.end_of_frame) begin
                r_cnt  <= '0;
                r_ovf  <= 1'b0;
                r_crc  <= 16'hFFFF;
                r_bank <= !r_bank;
            end else begin
                r_cnt <= n_cnt;
                r_ovf <= n_ovf;
                r_crc <= n_crc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_hdr <= n_hdr;
        end
    end

endmodule

// File: sv/mrs_fifo.sv
// Two-entry queue of frame descriptors between receive and execute sides.
// Depends on mrs_pkg.
module mrs_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mrs_pkg::t_desc i_desc,
    input  logic           i_pop,
    output mrs_pkg::t_desc o_head,
    output logic           o_full,
    output logic           o_empty
);

    mrs_pkg::t_desc r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_desc;
        end
    end

endmodule

// File: sv/mrs_back.sv
// Execute side: judges a frame, updates the holding registers, streams reply or status.
// Depends on mrs_pkg and mrs_out_if.
module mrs_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [7:0]              i_dev_addr,
    input  mrs_pkg::t_desc          i_desc,
    input  logic                    i_q_empty,
    output logic                    o_pop,
    output logic [mrs_pkg::FR_AW:0] o_ram_raddr,
    input  logic [7:0]              i_ram_rdata,
    mrs_out_if.source               o_tx
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RD_HI  = 8'b0000_0010,
        S_RD_LO  = 8'b0000_0100,
        S_WR     = 8'b0000_1000,
        S_SEND   = 8'b0001_0000,
        S_CRC_LO = 8'b0010_0000,
        S_CRC_HI = 8'b0100_0000,
        S_STATUS = 8'b1000_0000
    } t_state;

    t_state                       r_state;
    logic [15:0]                  r_hold [mrs_pkg::NUM_REGS];
    logic [mrs_pkg::REG_AW-1:0]   r_ridx;
    logic [4:0]                   r_i;
    logic [5:0]                   r_k, r_len;
    logic [15:0]                  r_crc;
    logic [7:0]                   r_hi;
    logic                         r_half;
    logic [mrs_pkg::FR_AW-1:0]    r_raddr;
    logic [2:0]                   r_code;
    logic                         r_out_v, r_tx_valid, r_tx_last;
    logic [7:0]                   r_tx_byte;
    logic [2:0]                   r_status;

    logic [7:0]  fn;
    logic [15:0] start, count;
    logic [16:0] span;
    logic [2:0]  code;
    logic        is_read;
    logic        can_emit;
    logic [7:0]  send_byte;
    logic [15:0] rd_word;
    logic        emit;
    logic [2:0]  emit_code;
    logic        emit_last, emit_valid;
    logic [7:0]  emit_byte;

    assign fn      = i_desc.hdr[1];
    assign start   = {i_desc.hdr[2], i_desc.hdr[3]};
    assign count   = {i_desc.hdr[4], i_desc.hdr[5]};
    assign span    = {1'b0, start} + {1'b0, count};
    assign is_read = (fn == mrs_pkg::FN_READ);

    always_comb begin
        code = mrs_pkg::ST_REPLIED;
        if (i_desc.ovf || i_desc.n < 7'd4) begin
            code = mrs_pkg::ST_LENGTH;
        end else if (!i_desc.crc_ok) begin
            code = mrs_pkg::ST_CRC_BAD;
        end else if (i_desc.hdr[0] == 8'h00) begin
            code = mrs_pkg::ST_BROADCAST;
        end else if (i_desc.hdr[0] != i_dev_addr) begin
            code = mrs_pkg::ST_OTHER;
        end else if (fn != mrs_pkg::FN_READ && fn != mrs_pkg::FN_WRITE_ONE
                     && fn != mrs_pkg::FN_WRITE_MANY) begin
            code = mrs_pkg::ST_BAD_FN;
        end else if (i_desc.n < 7'd8) begin
            code = mrs_pkg::ST_LENGTH;
        end else if (fn == mrs_pkg::FN_WRITE_ONE) begin
            if (i_desc.n != 7'd8) begin
                code = mrs_pkg::ST_LENGTH;
            end else if (start >= 16'(mrs_pkg::NUM_REGS)) begin
                code = mrs_pkg::ST_RANGE;
            end
        end else if (count == 16'd0 || count > 16'(mrs_pkg::NUM_REGS)
                     || span > 17'(mrs_pkg::NUM_REGS)) begin
            code = mrs_pkg::ST_RANGE;
        end else if (is_read) begin
            if (i_desc.n != 7'd8) begin
                code = mrs_pkg::ST_LENGTH;
            end
        end else if (i_desc.n != 7'd9 + {count[5:0], 1'b0}) begin
            code = mrs_pkg::ST_LENGTH;
        end else if (i_desc.hdr[6] != {count[6:0], 1'b0}) begin
            code = mrs_pkg::ST_RANGE;
        end
    end

    assign rd_word = r_hold[r_ridx];

    always_comb begin
        send_byte = i_desc.hdr[r_k[2:0]];
        if (is_read) begin
            if (r_k == 6'd0) begin
                send_byte = i_desc.hdr[0];
            end else if (r_k == 6'd1) begin
                send_byte = mrs_pkg::FN_READ;
            end else if (r_k == 6'd2) begin
                send_byte = {count[6:0], 1'b0};
            end else begin
                send_byte = r_half ? rd_word[7:0] : rd_word[15:8];
            end
        end
    end

    assign can_emit    = !r_out_v || o_tx.ready;
    assign o_ram_raddr = {i_desc.bank, r_raddr};

    always_comb begin
        emit       = 1'b0;
        emit_valid = 1'b1;
        emit_byte  = 8'h00;
        emit_last  = 1'b0;
        emit_code  = mrs_pkg::ST_REPLIED;
        o_pop      = 1'b0;
        case (r_state)
            S_SEND: begin
                emit      = can_emit;
                emit_byte = send_byte;
            end
            S_CRC_LO: begin
                emit      = can_emit;
                emit_byte = r_crc[7:0];
            end
            S_CRC_HI: begin
                emit      = can_emit;
                emit_byte = r_crc[15:8];
                emit_last = 1'b1;
                o_pop     = can_emit;
            end
            S_STATUS: begin
                emit       = can_emit;
                emit_valid = 1'b0;
                emit_last  = 1'b1;
                emit_code  = r_code;
                o_pop      = can_emit;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_v <= 1'b0;
            for (int j = 0; j < mrs_pkg::NUM_REGS; j++) begin
                r_hold[j] <= 16'(j + 1);
            end
        end else begin
            if (emit) begin
                r_out_v <= 1'b1;
            end else if (o_tx.ready) begin
                r_out_v <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        if (code != mrs_pkg::ST_REPLIED) begin
                            r_state <= S_STATUS;
                        end else if (fn == mrs_pkg::FN_WRITE_ONE) begin
                            r_hold[start[mrs_pkg::REG_AW-1:0]] <= count;
                            r_state <= S_SEND;
                        end else if (is_read) begin
                            r_state <= S_SEND;
                        end else begin
                            r_state <= S_RD_HI;
                        end
                    end
                end
                S_RD_HI: begin
                    r_state <= S_RD_LO;
                end
                S_RD_LO: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_hold[r_ridx] <= {r_hi, i_ram_rdata};
                    if (16'(r_i) + 16'd1 == count) begin
                        r_state <= S_SEND;
                    end else begin
                        r_state <= S_RD_HI;
                    end
                end
                S_SEND: begin
                    if (can_emit && r_k == r_len - 6'd1) begin
                        r_state <= S_CRC_LO;
                    end
                end
                S_CRC_LO: begin
                    if (can_emit) begin
                        r_state <= S_CRC_HI;
                    end
                end
                S_CRC_HI: begin
                    if (can_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                S_STATUS: begin
                    if (can_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_tx_valid <= emit_valid;
            r_tx_byte  <= emit_byte;
            r_tx_last  <= emit_last;
            r_status   <= emit_code;
        end
        case (r_state)
            S_IDLE: begin
                r_code  <= code;
                r_k     <= '0;
                r_crc   <= 16'hFFFF;
                r_half  <= 1'b0;
                r_i     <= '0;
                r_ridx  <= start[mrs_pkg::REG_AW-1:0];
                r_raddr <= mrs_pkg::FR_AW'(mrs_pkg::HDR_LEN);
                r_len   <= is_read ? 6'd3 + {count[4:0], 1'b0} : 6'd6;
            end
            S_RD_HI: begin
                r_raddr <= r_raddr + mrs_pkg::FR_AW'(1);
            end
            S_RD_LO: begin
                r_raddr <= r_raddr + mrs_pkg::FR_AW'(1);
                r_hi    <= i_ram_rdata;
            end
            S_WR: begin
                r_i    <= r_i + 5'd1;
                r_ridx <= r_ridx + mrs_pkg::REG_AW'(1);
            end
            S_SEND: begin
                if (can_emit) begin
                    r_k   <= r_k + 6'd1;
                    r_crc <= mrs_pkg::crc_byte(r_crc, send_byte);
                    if (is_read && r_k >= 6'd3) begin
                        r_half <= !r_half;
                        if (r_half) begin
                            r_ridx <= r_ridx + mrs_pkg::REG_AW'(1);
                        end
                    end
                end
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    assign o_tx.valid    = r_out_v;
    assign o_tx.tx_valid = r_tx_valid;
    assign o_tx.tx_byte  = r_tx_byte;
    assign o_tx.tx_last  = r_tx_last;
    assign o_tx.status   = r_status;

endmodule

// File: sv/modbus_rtu_register_slave_core.sv
// Modbus RTU holding-register slave: one received byte accepted per cycle while the queue has room.
// A frame is judged combinationally in S_IDLE; the state and output registers lie before its first result.
// Reply bytes leave one per cycle unless tx stalls; function 16 reads two stored bytes per register.
// Two frames may be buffered; the receive side stalls while both queue entries are in use.
// Synchronous active-low reset; holding register k resets to k plus one, device address to 2.
module modbus_rtu_register_slave_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mrs_in_if.sink     i_rx,
    mrs_out_if.source  o_tx
);

    `include "modbus_rtu_register_slave_core_assert.svh"

    logic [7:0]              r_dev_addr;
    logic                    push, pop, q_full, q_empty;
    mrs_pkg::t_desc          desc_in, desc_head;
    logic                    ram_we;
    logic [mrs_pkg::FR_AW:0] ram_waddr, ram_raddr;
    logic [7:0]              ram_wdata, ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= mrs_pkg::DEV_ADDR_RST;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    mrs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_rx),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_desc      (desc_in),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    mrs_ram #(
        .WIDTH (8),
        .DEPTH (mrs_pkg::RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mrs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc_in),
        .i_pop   (pop),
        .o_head  (desc_head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mrs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dev_addr  (r_dev_addr),
        .i_desc      (desc_head),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_tx        (o_tx)
    );

    `MRS_ASSERT_NEXT(a_eof_queued, i_rx.valid && i_rx.ready && i_rx.end_of_frame, !q_empty)
    `MRS_ASSERT_SAME(a_status_only_last, o_tx.valid && !o_tx.tx_valid,
                     o_tx.tx_last && o_tx.status != mrs_pkg::ST_REPLIED)
    `MRS_ASSERT_SAME(a_reply_ok, o_tx.valid && o_tx.tx_valid, o_tx.status == mrs_pkg::ST_REPLIED)
    `MRS_ASSERT_SAME(a_pop_nonempty, pop, !q_empty)

endmodule

// File: tb/sv/mrs_checker.sv
// Checker for the Modbus RTU register slave: predicts reply and status transactions.
// Depends on mrs_pkg and the mrs_in_if / mrs_out_if interfaces.
module mrs_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    mrs_in_if          rx,
    mrs_out_if         tx,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
        logic [2:0] status;
    } t_reply;

    t_reply      reply_q[$];
    logic [7:0]  dev_addr;
    logic [7:0]  frame_bytes[mrs_pkg::MAX_FRAME];
    int          frame_len;
    logic        frame_ovf;
    logic [15:0] regs[mrs_pkg::NUM_REGS];

    assign o_pending = reply_q.size();

    function automatic logic [15:0] crc_of(input logic [7:0] buf_b[], input int n);
        logic [15:0] c;
        c = 16'hFFFF;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, buf_b[i]};
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
            end
        end
        return c;
    endfunction

    task automatic push_status(input logic [2:0] st);
        reply_q.push_back('{1'b0, 8'h00, 1'b1, st});
    endtask

    task automatic push_frame(input logic [7:0] r[], input int n);
        logic [15:0] c;
        c = crc_of(r, n);
        for (int k = 0; k < n + 2; k++) begin
            reply_q.push_back('{1'b1, (k < n) ? r[k] : ((k == n) ? c[7:0] : c[15:8]),
                                k == n + 1, mrs_pkg::ST_REPLIED});
        end
    endtask

    task automatic judge_frame();
        logic [7:0] f[];
        logic [7:0] r[];
        int n;
        int start;
        int count;
        n = frame_len;
        f = new[mrs_pkg::MAX_FRAME];
        for (int i = 0; i < mrs_pkg::MAX_FRAME; i++) f[i] = frame_bytes[i];
        if (frame_ovf || n < 4) begin
            push_status(mrs_pkg::ST_LENGTH);
        end else if (crc_of(f, n - 2) != {f[n-1], f[n-2]}) begin
            push_status(mrs_pkg::ST_CRC_BAD);
        end else if (f[0] == 8'h00) begin
            push_status(mrs_pkg::ST_BROADCAST);
        end else if (f[0] != dev_addr) begin
            push_status(mrs_pkg::ST_OTHER);
        end else if (f[1] != mrs_pkg::FN_READ && f[1] != mrs_pkg::FN_WRITE_ONE
                     && f[1] != mrs_pkg::FN_WRITE_MANY) begin
            push_status(mrs_pkg::ST_BAD_FN);
        end else if (n < 8) begin
            push_status(mrs_pkg::ST_LENGTH);
        end else begin
            start = {f[2], f[3]};
            count = {f[4], f[5]};
            if (f[1] == mrs_pkg::FN_WRITE_ONE) begin
                if (n != 8) push_status(mrs_pkg::ST_LENGTH);
                else if (start >= mrs_pkg::NUM_REGS) push_status(mrs_pkg::ST_RANGE);
                else begin
                    regs[start] = {f[4], f[5]};
                    push_frame(f, 6);
                end
            end else if (count < 1 || count > mrs_pkg::NUM_REGS
                         || start + count > mrs_pkg::NUM_REGS) begin
                push_status(mrs_pkg::ST_RANGE);
            end else if (f[1] == mrs_pkg::FN_READ) begin
                if (n != 8) push_status(mrs_pkg::ST_LENGTH);
                else begin
                    r = new[3 + 2 * count];
                    r[0] = dev_addr;
                    r[1] = mrs_pkg::FN_READ;
                    r[2] = 8'(2 * count);
                    for (int i = 0; i < count; i++) begin
                        r[3 + 2*i] = regs[start + i][15:8];
                        r[4 + 2*i] = regs[start + i][7:0];
                    end
                    push_frame(r, 3 + 2 * count);
                end
            end else if (n != 9 + 2 * count) begin
                push_status(mrs_pkg::ST_LENGTH);
            end else if (f[6] != 8'(2 * count)) begin
                push_status(mrs_pkg::ST_RANGE);
            end else begin
                for (int i = 0; i < count; i++) regs[start + i] = {f[7 + 2*i], f[8 + 2*i]};
                push_frame(f, 6);
            end
        end
        frame_len = 0;
        frame_ovf = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            dev_addr  <= mrs_pkg::DEV_ADDR_RST;
            frame_len = 0;
            frame_ovf = 1'b0;
            for (int k = 0; k < mrs_pkg::NUM_REGS; k++) regs[k] = 16'(k + 1);
            reply_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) dev_addr <= i_cfg_wdata;
            if (rx.valid && rx.ready) begin
                if (frame_len < mrs_pkg::MAX_FRAME) begin
                    frame_bytes[frame_len] = rx.rx_byte;
                    frame_len++;
                end else begin
                    frame_ovf = 1'b1;
                end
                if (rx.end_of_frame) judge_frame();
            end
            if (tx.valid && tx.ready) begin
                got = '{tx.tx_valid, tx.tx_byte, tx.tx_last, tx.status};
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = reply_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/testbench.sv
// Top of the Modbus RTU register slave testbench: clock, reset, frame stimulus, verdict.
// Depends on mrs_pkg, the channel interfaces, mrs_checker and the block itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    int         fail_count;
    int         pending;
    int         src_idle;
    int         snk_idle;
    int         cycle_count;
    logic [7:0] cur_addr;

    mrs_in_if  rx_ch();
    mrs_out_if tx_ch();

    modbus_rtu_register_slave_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_rx(rx_ch.sink), .o_tx(tx_ch.source)
    );

    mrs_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .rx(rx_ch), .tx(tx_ch), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        tx_ch.ready = 1'b0;
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            tx_ch.ready <= ($urandom_range(99) >= snk_idle);
            cycle_count++;
            if (cycle_count > 2000000) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < src_idle) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.rx_byte      <= b;
        rx_ch.end_of_frame <= eof;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [15:0] frame_crc(input logic [7:0] f[$]);
        logic [15:0] c;
        c = 16'hFFFF;
        foreach (f[i]) c = mrs_pkg::crc_byte(c, f[i]);
        return c;
    endfunction

    // Send body, optionally with a good or corrupted CRC appended.
    task automatic send_frame(input logic [7:0] body[$], input bit add_crc, input bit bad_crc);
        logic [15:0] c;
        c = frame_crc(body);
        if (bad_crc) c = c ^ 16'(1 << $urandom_range(15));
        if (add_crc) begin
            body.push_back(c[7:0]);
            body.push_back(c[15:8]);
        end
        foreach (body[i]) send_byte(body[i], i == body.size() - 1);
    endtask

    task automatic send_req(input logic [7:0] addr, input logic [7:0] fn,
                            input logic [15:0] start, input logic [15:0] cnt,
                            input int nwords, input bit bad_crc);
        logic [7:0] body[$];
        body = {addr, fn, start[15:8], start[7:0], cnt[15:8], cnt[7:0]};
        if (fn == mrs_pkg::FN_WRITE_MANY) begin
            body.push_back(8'(2 * nwords));
            for (int i = 0; i < 2 * nwords; i++) body.push_back(8'($urandom));
        end
        send_frame(body, 1'b1, bad_crc);
    endtask

    task automatic drain();
        rx_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_addr(input logic [7:0] a);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_addr = a;
    endtask

    task automatic random_frame();
        int kind;
        int c;
        int s;
        logic [7:0] body[$];
        logic [7:0] a;
        kind = $urandom_range(99);
        a = ($urandom_range(9) == 0) ? 8'($urandom_range(0, 3)) : cur_addr;
        c = $urandom_range(1, 4);
        s = $urandom_range(0, mrs_pkg::NUM_REGS - c);
        if ($urandom_range(7) == 0) begin
            c = $urandom_range(16);
            s = $urandom_range(17);
        end
        if (kind < 30) begin
            send_req(a, mrs_pkg::FN_READ, 16'(s), 16'(c), 0, $urandom_range(15) == 0);
        end else if (kind < 55) begin
            send_req(a, mrs_pkg::FN_WRITE_ONE,
                     ($urandom_range(7) == 0) ? 16'($urandom) : 16'(s),
                     16'($urandom), 0, $urandom_range(15) == 0);
        end else if (kind < 80) begin
            send_req(a, mrs_pkg::FN_WRITE_MANY, 16'(s), 16'(c),
                     ($urandom_range(7) == 0) ? c + 1 : c, $urandom_range(15) == 0);
        end else if (kind < 90) begin
            send_req(a, 8'($urandom), 16'(s), 16'(c), 0, 1'b0);
        end else begin
            for (int i = 0; i < $urandom_range(1, 12); i++) body.push_back(8'($urandom));
            send_frame(body, $urandom_range(1), 1'b0);
        end
    endtask

    initial begin
        logic [7:0] body[$];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 8'h00;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = 8'h00;
        rx_ch.end_of_frame = 1'b0;
        src_idle = 32;
        snk_idle = 71;
        cur_addr = mrs_pkg::DEV_ADDR_RST;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_req(cur_addr, mrs_pkg::FN_READ, 16'd0, 16'd16, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_WRITE_ONE, 16'd15, 16'hFFFF, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_WRITE_MANY, 16'd12, 16'd4, 4, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_READ, 16'd15, 16'd1, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_READ, 16'd0, 16'd0, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_READ, 16'd8, 16'd9, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_WRITE_ONE, 16'h0010, 16'h0000, 0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_WRITE_MANY, 16'd0, 16'd2, 3, 1'b0);
        body = {cur_addr, mrs_pkg::FN_WRITE_MANY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h04,
                8'hAA, 8'h55};
        send_frame(body, 1'b1, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_READ, 16'd0, 16'd1, 0, 1'b1);
        send_req(8'h00, mrs_pkg::FN_WRITE_ONE, 16'd0, 16'h1234, 0, 1'b0);
        send_req(8'hFF, mrs_pkg::FN_READ, 16'd0, 16'd1, 0, 1'b0);
        send_req(cur_addr, 8'h07, 16'd0, 16'd1, 0, 1'b0);
        body = {cur_addr, mrs_pkg::FN_READ, 8'h00};
        send_frame(body, 1'b1, 1'b0);
        body = {8'h01, 8'h02};
        send_frame(body, 1'b0, 1'b0);
        body = {};
        for (int i = 0; i < 65; i++) body.push_back(8'($urandom));
        send_frame(body, 1'b0, 1'b0);
        send_req(cur_addr, mrs_pkg::FN_READ, 16'd0, 16'd16, 0, 1'b0);

        set_addr(8'd247);
        for (int i = 0; i < 1; i++) random_frame();
        set_addr(8'd1);
        for (int i = 0; i < 1; i++) random_frame();
        set_addr(8'hFF);
        send_req(8'hFF, mrs_pkg::FN_READ, 16'd0, 16'd2, 0, 1'b0);
        set_addr(8'h00);
        send_req(8'h00, mrs_pkg::FN_READ, 16'd0, 16'd2, 0, 1'b0);
        set_addr(8'h5A);
        for (int i = 0; i < 1; i++) random_frame();
        src_idle = 71;
        snk_idle = 32;
        for (int i = 0; i < 1; i++) random_frame();
        set_addr(8'hA5);
        for (int i = 0; i < 1; i++) random_frame();
        src_idle = 0;
        snk_idle = 0;
        for (int i = 0; i < 2; i++) random_frame();

        drain();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
